FILE: design/periodic_timer_slot_table_unit_assert.svh
// Assertion macros for the periodic timer slot table
`ifndef PERIODIC_TIMER_SLOT_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_TIMER_SLOT_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define PTST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ptst_pkg.sv
// Types and codes shared by the periodic timer slot table
`timescale 1ns / 1ps
`default_nettype none

package ptst_pkg;

  typedef enum logic [2:0] {
    FN_CREATE = 3'd0,
    FN_KILL   = 3'd1,
    FN_SETPER = 3'd2,
    FN_SETCNT = 3'd3,
    FN_ADDCNT = 3'd4,
    FN_TICK   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADARG   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FIRE  = 1'b1;

  typedef struct packed {
    logic        valid;
    func_e       func;
    logic [7:0]  id;
    logic [31:0] period;
    logic [31:0] count;
    logic        bad;
    logic        claimed;
    logic [7:0]  slot;
    logic        hit;
  } tok_t;

endpackage

`default_nettype wire

FILE: design/ptst_if.sv
// Handshake interfaces for command words and result words
`timescale 1ns / 1ps
`default_nettype none

interface ptst_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  slot_id;
  logic [31:0] period_ms;
  logic [31:0] call_count;

  modport source (output valid, func, slot_id, period_ms, call_count, input ready);
  modport sink   (input valid, func, slot_id, period_ms, call_count, output ready);
endinterface

interface ptst_rsp_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] status;
  logic [7:0] out_slot;
  logic       last;

  modport source (output valid, kind, status, out_slot, last, input ready);
  modport sink   (input valid, kind, status, out_slot, last, output ready);
endinterface

`default_nettype wire

FILE: design/ptst_cell.sv
// One timer slot: holds its state and passes the command token to the next slot
`timescale 1ns / 1ps
`default_nettype none

module ptst_cell
  import ptst_pkg::*;
#(
  parameter int SLOT_IDX = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic [31:0] time_i,
  input  wire tok_t        tok_i,
  output tok_t             tok_o,
  output logic             fire_o
);

  logic        used_q;
  logic [31:0] period_q;
  logic [31:0] limit_q;
  logic [31:0] calls_q;
  logic [31:0] due_q;
  tok_t        tok_q;
  tok_t        tok_d;

  logic        fire;
  logic        claim;
  logic        target;
  logic [31:0] calls_inc;
  logic [31:0] mag;
  logic        neg;

  always_comb begin
    calls_inc = calls_q + 32'd1;
    mag       = 32'd0 - tok_i.count;
    neg       = tok_i.count[31];
    fire      = tok_i.valid && (tok_i.func == FN_TICK) && used_q && !(time_i < due_q);
    claim     = tok_i.valid && (tok_i.func == FN_CREATE) && !used_q && !tok_i.claimed;
    target    = tok_i.valid && !tok_i.bad && (tok_i.id == 8'(SLOT_IDX))
                && (tok_i.func inside {FN_KILL, FN_SETPER, FN_SETCNT, FN_ADDCNT});
    tok_d     = tok_i;
    if (claim) begin
      tok_d.claimed = 1'b1;
      tok_d.slot    = 8'(SLOT_IDX);
    end
    if (target) begin
      tok_d.hit = used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
      if (fire && (limit_q != 32'd0) && (calls_inc >= limit_q)) begin
        used_q <= 1'b0;
      end
      if (claim) begin
        used_q <= 1'b1;
      end
      if (target && used_q) begin
        case (tok_i.func)
          FN_KILL: used_q <= 1'b0;
          FN_ADDCNT: begin
            if (neg && (limit_q <= mag)) begin
              used_q <= 1'b0;
            end
          end
          default: used_q <= used_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (fire) begin
        due_q   <= time_i + period_q;
        calls_q <= calls_inc;
      end
      if (claim) begin
        period_q <= tok_i.period;
        limit_q  <= tok_i.count;
        calls_q  <= 32'd0;
        due_q    <= time_i + tok_i.period;
      end
      if (target && used_q) begin
        case (tok_i.func)
          FN_SETPER: period_q <= tok_i.period;
          FN_SETCNT: limit_q  <= tok_i.count;
          FN_ADDCNT: begin
            if (!neg) begin
              limit_q <= limit_q + tok_i.count;
            end else if (limit_q > mag) begin
              limit_q <= limit_q - mag;
            end
          end
          default: period_q <= period_q;
        endcase
      end
    end
  end

  assign tok_o  = tok_q;
  assign fire_o = fire;

endmodule

`default_nettype wire

FILE: design/periodic_timer_slot_table_unit.sv
// Top level of the periodic timer slot table
// Each command word passes once along a row of TIMER_SLOTS slot cells, one
// cell per cycle while the result side does not hold off a reply or fire
// word; the next word is taken only after the current one has come out of
// the last cell. Create claims the lowest free slot; kill, set
// period, set count and add count act on the addressed slot; a tick advances
// the millisecond time and emits one fire word per due slot in slot order,
// the final one flagged last. A tick with no due slot emits nothing.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_slot_table_unit
  import ptst_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ptst_req_if.sink    req_i,
  ptst_rsp_if.source  rsp_o
);

  `include "periodic_timer_slot_table_unit_assert.svh"

  tok_t                   tok [TIMER_SLOTS+1];
  logic [TIMER_SLOTS-1:0] fire;

  tok_t        entry_q;
  logic        busy_q;
  logic [31:0] time_q;
  logic        pend_q;
  logic [7:0]  pend_slot_q;

  logic        out_valid_q;
  logic        out_kind_q;
  status_e     out_status_q;
  logic [7:0]  out_slot_q;
  logic        out_last_q;

  logic        accept;
  logic        fire_any;
  logic [7:0]  fire_slot;
  tok_t        end_tok;
  logic        need_emit;
  logic        out_free;
  logic        en;
  func_e       in_func;
  status_e     reply_status;
  logic [7:0]  reply_slot;

  assign tok[0]  = entry_q;
  assign end_tok = tok[TIMER_SLOTS];

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    ptst_cell #(
      .SLOT_IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .time_i(time_q),
      .tok_i (tok[g]),
      .tok_o (tok[g+1]),
      .fire_o(fire[g])
    );
  end

  always_comb begin
    fire_slot = 8'd0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (fire[i]) begin
        fire_slot = 8'(i);
      end
    end
  end

  always_comb begin
    reply_slot = 8'd0;
    if (end_tok.func == FN_CREATE) begin
      reply_status = end_tok.claimed ? ST_OK : ST_OVERFLOW;
      reply_slot   = end_tok.claimed ? end_tok.slot : 8'd0;
    end else if (end_tok.bad) begin
      reply_status = ST_BADARG;
    end else if (end_tok.hit) begin
      reply_status = ST_OK;
    end else begin
      reply_status = ST_NOTFOUND;
    end
  end

  assign in_func   = func_e'(req_i.func);
  assign accept    = req_i.valid && req_i.ready;
  assign fire_any  = |fire;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign need_emit = (fire_any && pend_q)
                     || (end_tok.valid && ((end_tok.func != FN_TICK) || pend_q));
  assign en        = out_free || !need_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q      <= '0;
      busy_q       <= 1'b0;
      time_q       <= 32'd0;
      pend_q       <= 1'b0;
      pend_slot_q  <= 8'd0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_REPLY;
      out_status_q <= ST_OK;
      out_slot_q   <= 8'd0;
      out_last_q   <= 1'b0;
    end else begin
      if (en && need_emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (en) begin
        if (!accept) begin
          entry_q.valid <= 1'b0;
        end
        if (fire_any) begin
          if (pend_q) begin
            out_kind_q   <= KIND_FIRE;
            out_status_q <= ST_OK;
            out_slot_q   <= pend_slot_q;
            out_last_q   <= 1'b0;
          end
          pend_q      <= 1'b1;
          pend_slot_q <= fire_slot;
        end
        if (end_tok.valid) begin
          busy_q <= 1'b0;
          if (end_tok.func == FN_TICK) begin
            if (pend_q) begin
              out_kind_q   <= KIND_FIRE;
              out_status_q <= ST_OK;
              out_slot_q   <= pend_slot_q;
              out_last_q   <= 1'b1;
              pend_q       <= 1'b0;
            end
          end else begin
            out_kind_q   <= KIND_REPLY;
            out_status_q <= reply_status;
            out_slot_q   <= reply_slot;
            out_last_q   <= 1'b1;
          end
        end
      end
      if (accept) begin
        busy_q          <= 1'b1;
        entry_q.valid   <= 1'b1;
        entry_q.func    <= in_func;
        entry_q.id      <= req_i.slot_id;
        entry_q.period  <= req_i.period_ms;
        entry_q.count   <= req_i.call_count;
        entry_q.bad     <= !(in_func inside {FN_KILL, FN_SETPER, FN_SETCNT, FN_ADDCNT})
                           || (req_i.slot_id >= 8'(TIMER_SLOTS));
        entry_q.claimed <= 1'b0;
        entry_q.slot    <= 8'd0;
        entry_q.hit     <= 1'b0;
        if (in_func == FN_TICK) begin
          time_q <= time_q + 32'd1;
        end
      end
    end
  end

  assign req_i.ready    = !busy_q;
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.kind     = out_kind_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.out_slot = out_slot_q;
  assign rsp_o.last     = out_last_q;

  `PTST_ASSERT_NOW(a_idle_empty, clk_i, rst_ni, !busy_q, !pend_q && !end_tok.valid && !entry_q.valid, "idle with word in flight")
  `PTST_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy_q, "accepted word not tracked")
  `PTST_ASSERT_NOW(a_fire_excl, clk_i, rst_ni, fire_any, !end_tok.valid && $onehot(fire), "fire outside scan")

endmodule

`default_nettype wire

FILE: tb/tb_periodic_timer_slot_table_unit.sv
// Self-checking testbench: command words vs. a predicted timer table, random handshake idling
`timescale 1ns / 1ps
`default_nettype none

module tb_periodic_timer_slot_table_unit;
  import ptst_pkg::*;

  localparam int SLOTS = 16;
  localparam int N_RANDOM = 320;
  localparam int CALM_TAIL = 48;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AFTER = 60;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [2:0] FN_RSVD_LO = 3'd6;
  localparam logic [2:0] FN_RSVD_HI = 3'd7;

  typedef struct {
    logic [2:0]  func;
    logic [7:0]  id;
    logic [31:0] period;
    logic [31:0] count;
  } cmd_t;

  typedef struct {
    logic       kind;
    logic [1:0] status;
    logic [7:0] slot;
    logic       last;
  } rsp_t;

  logic clk_i;
  logic rst_ni;

  ptst_req_if req_bus ();
  ptst_rsp_if rsp_bus ();

  periodic_timer_slot_table_unit #(
    .TIMER_SLOTS(SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  cmd_t cmd_q[$];
  rsp_t awaited[$];
  cmd_t cur_cmd;
  int   n_total;
  int   words_taken;
  int   err_cnt;
  int   gap_left;
  int   stall_left;
  bit   long_hold_done;
  int   quiet_cycles;

  bit          tt_used[SLOTS];
  logic [31:0] tt_period[SLOTS];
  logic [31:0] tt_limit[SLOTS];
  logic [31:0] tt_calls[SLOTS];
  logic [31:0] tt_due[SLOTS];
  logic [31:0] tt_now;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic push_reply(input logic [1:0] st, input logic [7:0] slot);
    rsp_t r;
    r.kind = KIND_REPLY;
    r.status = st;
    r.slot = slot;
    r.last = 1'b1;
    awaited.push_back(r);
  endtask

  task automatic timer_table_step(input cmd_t c);
    rsp_t r;
    logic [31:0] mag;
    bit found;
    int n_fire;
    n_fire = 0;
    found = 1'b0;
    if (c.func == FN_TICK) begin
      tt_now = tt_now + 32'd1;
      for (int i = 0; i < SLOTS; i++) begin
        if (tt_used[i] && tt_now >= tt_due[i]) begin
          tt_due[i] = tt_now + tt_period[i];
          tt_calls[i] = tt_calls[i] + 32'd1;
          if (tt_limit[i] != 32'd0 && tt_calls[i] >= tt_limit[i]) tt_used[i] = 1'b0;
          r.kind = KIND_FIRE;
          r.status = ST_OK;
          r.slot = 8'(i);
          r.last = 1'b0;
          awaited.push_back(r);
          n_fire++;
        end
      end
      if (n_fire > 0) awaited[awaited.size() - 1].last = 1'b1;
    end else if (c.func == FN_CREATE) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && !tt_used[i]) begin
          found = 1'b1;
          tt_used[i] = 1'b1;
          tt_period[i] = c.period;
          tt_limit[i] = c.count;
          tt_calls[i] = 32'd0;
          tt_due[i] = tt_now + c.period;
          push_reply(ST_OK, 8'(i));
        end
      end
      if (!found) push_reply(ST_OVERFLOW, 8'd0);
    end else if (c.func == FN_RSVD_LO || c.func == FN_RSVD_HI || c.id >= SLOTS) begin
      push_reply(ST_BADARG, 8'd0);
    end else if (!tt_used[c.id]) begin
      push_reply(ST_NOTFOUND, 8'd0);
    end else begin
      case (c.func)
        FN_KILL: tt_used[c.id] = 1'b0;
        FN_SETPER: tt_period[c.id] = c.period;
        FN_SETCNT: tt_limit[c.id] = c.count;
        default: begin
          if (c.count[31]) begin
            mag = 32'd0 - c.count;
            if (tt_limit[c.id] <= mag) tt_used[c.id] = 1'b0;
            else tt_limit[c.id] = tt_limit[c.id] - mag;
          end else begin
            tt_limit[c.id] = tt_limit[c.id] + c.count;
          end
        end
      endcase
      push_reply(ST_OK, 8'd0);
    end
  endtask

  task automatic add_cmd(input logic [2:0] f, input logic [7:0] id,
                         input logic [31:0] per, input logic [31:0] cnt);
    cmd_t c;
    c.func = f;
    c.id = id;
    c.period = per;
    c.count = cnt;
    cmd_q.push_back(c);
  endtask

  // Command side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        timer_table_step(cur_cmd);
        words_taken++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (gap_left > 0) begin
          req_bus.valid <= 1'b0;
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.func <= cur_cmd.func;
          req_bus.slot_id <= cur_cmd.id;
          req_bus.period_ms <= cur_cmd.period;
          req_bus.call_count <= cur_cmd.count;
          if (cmd_q.size() >= CALM_TAIL && $urandom_range(0, 4) == 0)
            gap_left = $urandom_range(1, 13);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (awaited.size() == 0) begin
          flag_mismatch($sformatf("unexpected word kind=%0d status=%0d slot=%0d last=%0d",
                                  rsp_bus.kind, rsp_bus.status, rsp_bus.out_slot,
                                  rsp_bus.last));
        end else begin
          rsp_t e;
          e = awaited.pop_front();
          if (rsp_bus.kind !== e.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", rsp_bus.kind, e.kind));
          if (rsp_bus.status !== e.status)
            flag_mismatch($sformatf("status %0d, want %0d", rsp_bus.status, e.status));
          if (rsp_bus.out_slot !== e.slot)
            flag_mismatch($sformatf("out_slot %0d, want %0d", rsp_bus.out_slot, e.slot));
          if (rsp_bus.last !== e.last)
            flag_mismatch($sformatf("last %0d, want %0d", rsp_bus.last, e.last));
        end
      end
      if (!long_hold_done && words_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else if (cmd_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int sel;
    int pick;
    logic [2:0]  f;
    logic [7:0]  id;
    logic [31:0] per;
    logic [31:0] cnt;

    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.func = FN_TICK;
    req_bus.slot_id = 8'd0;
    req_bus.period_ms = 32'd0;
    req_bus.call_count = 32'd0;
    rsp_bus.ready = 1'b0;
    words_taken = 0;
    err_cnt = 0;
    quiet_cycles = 0;
    long_hold_done = 1'b0;
    tt_now = 32'd0;
    for (int i = 0; i < SLOTS; i++) tt_used[i] = 1'b0;

    add_cmd(FN_TICK, 8'd0, 32'd0, 32'd0);
    add_cmd(FN_KILL, 8'd3, 32'd0, 32'd0);
    add_cmd(FN_SETPER, 8'd16, 32'd5, 32'd0);
    add_cmd(FN_SETCNT, 8'd255, 32'd0, 32'd7);
    add_cmd(FN_RSVD_LO, 8'd0, 32'd0, 32'd0);
    add_cmd(FN_RSVD_HI, 8'd1, 32'd0, 32'd0);
    add_cmd(FN_CREATE, 8'd0, 32'd1, 32'd2);
    add_cmd(FN_CREATE, 8'd0, 32'hFFFF_FFFF, 32'd0);
    add_cmd(FN_CREATE, 8'd0, 32'd0, 32'd1);
    for (int i = 3; i < SLOTS; i++)
      add_cmd(FN_CREATE, 8'd0, 32'($urandom_range(0, 3)), 32'($urandom_range(0, 3)));
    add_cmd(FN_CREATE, 8'd0, 32'd4, 32'd4);
    add_cmd(FN_ADDCNT, 8'd3, 32'd0, 32'h8000_0000);
    add_cmd(FN_ADDCNT, 8'd0, 32'd0, 32'h7FFF_FFFF);
    add_cmd(FN_ADDCNT, 8'd0, 32'd0, 32'hFFFF_FFFF);
    add_cmd(FN_SETCNT, 8'd4, 32'd0, 32'd3);
    add_cmd(FN_SETPER, 8'd4, 32'd0, 32'd0);
    add_cmd(FN_TICK, 8'd0, 32'd0, 32'd0);
    add_cmd(FN_KILL, 8'd5, 32'd0, 32'd0);
    add_cmd(FN_CREATE, 8'd0, 32'd2, 32'd0);

    for (int k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, SLOTS - 1));
      sel = $urandom_range(0, 9);
      if (sel < 6) per = 32'($urandom_range(0, 6));
      else if (sel == 6) per = $urandom;
      else if (sel == 7) per = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      else per = 32'($urandom_range(7, 40));
      sel = $urandom_range(0, 9);
      if (sel < 3) cnt = 32'd0;
      else if (sel < 7) cnt = 32'($urandom_range(1, 5));
      else if (sel == 7) cnt = $urandom;
      else cnt = 32'd0 - 32'($urandom_range(1, 6));
      if (pick < 22) f = FN_CREATE;
      else if (pick < 55) f = FN_TICK;
      else if (pick < 65) f = FN_KILL;
      else if (pick < 73) f = FN_SETPER;
      else if (pick < 80) f = FN_SETCNT;
      else if (pick < 94) f = FN_ADDCNT;
      else if (pick < 97) f = FN_RSVD_LO;
      else f = FN_RSVD_HI;
      add_cmd(f, id, per, cnt);
    end
    n_total = cmd_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (words_taken == n_total);
    wait (awaited.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
